[sv/row_column_projection_minimum_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the row/column projection minimum locator
// Clocked, reset-gated assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ROW_COLUMN_PROJECTION_MINIMUM_ASSERT_SVH
`define ROW_COLUMN_PROJECTION_MINIMUM_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define RCPM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication from a condition to the next cycle outside reset
`define RCPM_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[sv/rcpm_pkg.sv]
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared widths, defaults and register codes of the projection minimum locator.
// ----------------------------------------------------------------------------
package rcpm_pkg;

  // Field and register widths fixed by the interface
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int IDX_W     = 8;
  localparam int SUM_W     = 16;
  localparam int BEST_W    = SUM_W + 1;
  localparam int OUT_W     = 2 * IDX_W + 2 * SUM_W;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 8;

  // Register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 9'd256;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 9'd256;

  // Saturation ceiling and "no candidate yet" marker
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [BEST_W-1:0] NONE_YET = '1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // One result transaction, first field in the highest bits
  typedef struct packed {
    logic [SUM_W-1:0] min_row_sum;
    logic [SUM_W-1:0] min_col_sum;
    logic [IDX_W-1:0] center_row;
    logic [IDX_W-1:0] center_col;
  } result_t;

endpackage

[sv/row_column_projection_minimum.sv]
// ----------------------------------------------------------------------------
// row_column_projection_minimum
// Locates the darkest row and column of a gray frame from its projections.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  s_axis    in         one pixel, raster order
//  m_axis    out        one result after the last pixel of each frame
//  cfg       in         register write, no handshake
//
//  One pixel per clock while no result is blocked; an accepted pixel is held
//  in the work stage, and the result is registered when the last one retires.
//  The per-column read-modify-write of the column-sum RAM sets that rate.
//  s_axis_tready drops only while a finished result waits at m_axis and the
//  next pixel to retire would make another one.
//  Reset clears control state; the column-sum RAM needs no clearing pass.
//  Any register write restarts the frame.
// ----------------------------------------------------------------------------
module row_column_projection_minimum
  import rcpm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // Pixel stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // [7:0] center_col, [15:8] center_row,
                                               // [31:16] min_col_sum, [47:32] min_row_sum
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CPOS_W = $clog2(MAX_WIDTH);
  localparam int RPOS_W = $clog2(MAX_HEIGHT);
  localparam int CW_W   = (CFG_W > CPOS_W + 1) ? CFG_W : CPOS_W + 1;
  localparam int CH_W   = (CFG_W > RPOS_W + 1) ? CFG_W : RPOS_W + 1;
  localparam logic [PIX_W-1:0] PIX_MASK =
    (PIXEL_BITS >= PIX_W) ? '1 : PIX_W'((1 << PIXEL_BITS) - 1);

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  // Position counters
  logic [CPOS_W-1:0] col_pos;
  logic [RPOS_W-1:0] row_pos;

  // Work stage
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pixel;
  logic [CPOS_W-1:0] s1_col;
  logic [RPOS_W-1:0] s1_row;
  logic              s1_first_row;
  logic              s1_last_row;
  logic              s1_last_col;

  // Column-sum forwarding across a same-edge write and read
  logic              byp_hit;
  logic [SUM_W-1:0]  byp_data;
  logic [SUM_W-1:0]  ram_rdata;

  // Trackers
  logic [SUM_W-1:0]  row_acc;
  logic [BEST_W-1:0] best_row_sum;
  logic [IDX_W-1:0]  best_row_index;
  logic [BEST_W-1:0] best_col_sum;
  logic [IDX_W-1:0]  best_col_index;

  // Output register
  result_t           out_data;

  logic [CW_W-1:0]   w_eff;
  logic [CH_W-1:0]   h_eff;
  logic              col_last;
  logic              row_last;
  logic              accept;
  logic              s1_frame_end;
  logic              s1_fire;
  logic [SUM_W-1:0]  col_old;
  logic [SUM_W-1:0]  colval;
  logic [SUM_W-1:0]  row_new;
  logic [BEST_W-1:0] best_row_sum_next;
  logic [IDX_W-1:0]  best_row_index_next;
  logic [BEST_W-1:0] best_col_sum_next;
  logic [IDX_W-1:0]  best_col_index_next;

  // Clamp the frame dimensions into 1..MAX
  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW_W'(1);
    end else if (CW_W'(frame_width) > CW_W'(MAX_WIDTH)) begin
      w_eff = CW_W'(MAX_WIDTH);
    end else begin
      w_eff = CW_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = CH_W'(1);
    end else if (CH_W'(frame_height) > CH_W'(MAX_HEIGHT)) begin
      h_eff = CH_W'(MAX_HEIGHT);
    end else begin
      h_eff = CH_W'(frame_height);
    end
  end

  assign col_last = (CW_W'(col_pos) == w_eff - CW_W'(1));
  assign row_last = (CH_W'(row_pos) == h_eff - CH_W'(1));

  // Handshake: stall only when a frame end meets a full output register
  assign s1_frame_end  = s1_last_col && s1_last_row;
  assign s1_fire       = s1_valid && (!s1_frame_end || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Column and row sums for the pixel in the work stage
  always_comb begin
    col_old = byp_hit ? byp_data : ram_rdata;
    colval  = s1_first_row ? SUM_W'(s1_pixel) : sat_add(col_old, s1_pixel);
    row_new = sat_add(row_acc, s1_pixel);

    best_col_sum_next   = best_col_sum;
    best_col_index_next = best_col_index;
    if (s1_last_row && ({1'b0, colval} < best_col_sum)) begin
      best_col_sum_next   = {1'b0, colval};
      best_col_index_next = IDX_W'(s1_col);
    end

    best_row_sum_next   = best_row_sum;
    best_row_index_next = best_row_index;
    if (s1_last_col && ({1'b0, row_new} <= best_row_sum)) begin
      best_row_sum_next   = {1'b0, row_new};
      best_row_index_next = IDX_W'(s1_row);
    end
  end

  rcpm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (colval),
    .re    (accept),
    .raddr (col_pos),
    .rdata (ram_rdata)
  );

  // Capture the pixel and its position; forward a write that lands on the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel     <= s_axis_tdata & PIX_MASK;
      s1_col       <= col_pos;
      s1_row       <= row_pos;
      s1_first_row <= (row_pos == '0);
      s1_last_row  <= row_last;
      s1_last_col  <= col_last;
      byp_hit      <= s1_fire && (s1_col == col_pos);
      byp_data     <= colval;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (s1_fire && s1_frame_end) begin
      out_data.center_col  <= best_col_index_next;
      out_data.center_row  <= best_row_index_next;
      out_data.min_col_sum <= best_col_sum_next[SUM_W-1:0];
      out_data.min_row_sum <= best_row_sum_next[SUM_W-1:0];
    end
  end

  assign m_axis_tdata = out_data;

  // Control state: registers, positions, trackers, valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
      col_pos        <= '0;
      row_pos        <= '0;
      s1_valid       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      row_acc        <= '0;
      best_row_sum   <= NONE_YET;
      best_row_index <= '0;
      best_col_sum   <= NONE_YET;
      best_col_index <= '0;
    end else begin
      // Advance the raster position
      if (accept) begin
        if (col_last) begin
          col_pos <= '0;
          row_pos <= row_last ? '0 : row_pos + RPOS_W'(1);
        end else begin
          col_pos <= col_pos + CPOS_W'(1);
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      // Retire the work stage into the trackers
      if (s1_fire) begin
        if (s1_frame_end) begin
          row_acc        <= '0;
          best_row_sum   <= NONE_YET;
          best_row_index <= '0;
          best_col_sum   <= NONE_YET;
          best_col_index <= '0;
        end else begin
          row_acc        <= s1_last_col ? '0 : row_new;
          best_row_sum   <= best_row_sum_next;
          best_row_index <= best_row_index_next;
          best_col_sum   <= best_col_sum_next;
          best_col_index <= best_col_index_next;
        end
      end

      if (s1_fire && s1_frame_end) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // Register write: store it and restart the frame
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
        col_pos        <= '0;
        row_pos        <= '0;
        row_acc        <= '0;
        best_row_sum   <= NONE_YET;
        best_row_index <= '0;
        best_col_sum   <= NONE_YET;
        best_col_index <= '0;
      end
    end
  end

endmodule

[sv/rcpm_ram.sv]
// ----------------------------------------------------------------------------
// rcpm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rcpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old contents on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/rcpm_checker.sv]
// ----------------------------------------------------------------------------
// rcpm_checker
// Port-level checks of the projection minimum locator, bound to the top level.
// ----------------------------------------------------------------------------
`include "row_column_projection_minimum_assert.svh"

module rcpm_checker
  import rcpm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // Result offered but not taken
  logic out_stall;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Hold a stalled result transaction
  `RCPM_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

  // Drop input ready only behind a blocked result
  `RCPM_ASSERT(a_ready_hold, !s_axis_tready |-> out_stall, "input stalled without backpressure")

  // Retire a result only when it was taken
  `RCPM_ASSERT(a_out_taken, $fell(m_axis_tvalid) |-> $past(m_axis_tready || rst), "result lost")

endmodule

bind row_column_projection_minimum rcpm_checker u_rcpm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
